// File: rtl/core/pwic_pkg.sv
`timescale 1ns / 1ps

package pwic_pkg;

	localparam int CH_W           = 8;
	localparam int WT_W           = 16;
	localparam int WSUM_W         = 18;
	localparam int PROD_W         = CH_W + WT_W;
	localparam int SUM_W          = PROD_W + 2;
	localparam int SCALED_W       = SUM_W + WT_W;
	localparam int FRAC_SHIFT     = 12;
	localparam int NUM_W          = SCALED_W + 8 - FRAC_SHIFT;
	localparam int Q_W            = 8;
	localparam int DIV_BITS       = 2;
	localparam int DIV_STAGES     = Q_W / DIV_BITS;
	localparam int DIFF_W         = Q_W + 2;
	localparam int GAIN_W         = 16;
	localparam int T_W            = DIFF_W + GAIN_W + 1;
	localparam int CONTRAST_SHIFT = 13;
	localparam int CONTRAST_BIAS  = 255 * 4096;
	localparam int REG_IDX_W      = 3;

	localparam logic [WT_W-1:0]   Q_ONE          = 16'd4096;
	localparam logic [WSUM_W-1:0] W_ONE          = 18'd4096;
	localparam logic              MODE_RST       = 1'b0;
	localparam logic [WT_W-1:0]   RED_WT_RST     = 16'd4096;
	localparam logic [WT_W-1:0]   GREEN_WT_RST   = 16'd4096;
	localparam logic [WT_W-1:0]   BLUE_WT_RST    = 16'd4096;
	localparam logic [WT_W-1:0]   ALPHA_WT_RST   = 16'd0;
	localparam logic [WT_W-1:0]   SCALE_RST      = 16'd4096;
	localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd4096;
	localparam longint unsigned   WSUM_RST       = 64'd12288;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COMBINE_MODE = 3'd0,
		REG_RED_WEIGHT   = 3'd1,
		REG_GREEN_WEIGHT = 3'd2,
		REG_BLUE_WEIGHT  = 3'd3,
		REG_ALPHA_WEIGHT = 3'd4,
		REG_SCALE        = 3'd5,
		REG_CONTRAST     = 3'd6
	} reg_idx_t;

endpackage

// File: rtl/core/pwic_pixel_if.sv
`timescale 1ns / 1ps

interface pwic_pixel_if import pwic_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red_in;
	logic [CH_W-1:0] green_in;
	logic [CH_W-1:0] blue_in;
	logic [CH_W-1:0] alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// File: rtl/core/pwic_gray_if.sv
`timescale 1ns / 1ps

interface pwic_gray_if import pwic_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [Q_W-1:0]  gray_level;
	logic [CH_W-1:0] alpha_out;

	modport source (output valid, gray_level, alpha_out, input ready);
	modport sink (input valid, gray_level, alpha_out, output ready);
endinterface

// File: rtl/core/pwic_cfg_if.sv
`timescale 1ns / 1ps

interface pwic_cfg_if import pwic_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [WT_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/pwic_div.sv
`timescale 1ns / 1ps

module pwic_div import pwic_pkg::*; #(
	parameter int DEN_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [CH_W-1:0]  alpha_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [Q_W-1:0]   quo,
	output logic [CH_W-1:0]  alpha_out
);

	localparam int RW   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
	localparam int LAST = DIV_STAGES - 1;

	logic [RW-1:0]   den_ext;
	logic            v_s     [DIV_STAGES];
	logic            rdy     [DIV_STAGES];
	logic [RW-1:0]   rem_s   [DIV_STAGES];
	logic [Q_W-1:0]  quo_s   [DIV_STAGES];
	logic            sat_s   [DIV_STAGES];
	logic [CH_W-1:0] alpha_s [DIV_STAGES];

	assign den_ext = RW'(den);

	genvar j;
	generate
		for (j = 0; j < DIV_STAGES; j++) begin : g_stage
			localparam int K_HI = Q_W - 1 - DIV_BITS * j;
			localparam int K_LO = K_HI - 1;

			logic            v_in;
			logic [RW-1:0]   rem_in;
			logic [Q_W-1:0]  quo_in;
			logic            sat_in;
			logic [CH_W-1:0] alpha_pre;
			logic [RW-1:0]   rem_mid;
			logic [RW-1:0]   rem_nx;
			logic [Q_W-1:0]  quo_nx;

			if (j == 0) begin : g_first
				assign v_in      = in_valid;
				assign rem_in    = RW'(num);
				assign quo_in    = '0;
				assign sat_in    = RW'(num) >= (den_ext << Q_W);
				assign alpha_pre = alpha_in;
			end else begin : g_next
				assign v_in      = v_s[j-1];
				assign rem_in    = rem_s[j-1];
				assign quo_in    = quo_s[j-1];
				assign sat_in    = sat_s[j-1];
				assign alpha_pre = alpha_s[j-1];
			end

			if (j == LAST) begin : g_rdy_last
				assign rdy[j] = !v_s[j] || out_ready;
			end else begin : g_rdy_mid
				assign rdy[j] = !v_s[j] || rdy[j+1];
			end

			always_comb begin
				quo_nx  = quo_in;
				rem_mid = rem_in;
				if (rem_in >= (den_ext << K_HI)) begin
					rem_mid      = rem_in - (den_ext << K_HI);
					quo_nx[K_HI] = 1'b1;
				end
				rem_nx = rem_mid;
				if (rem_mid >= (den_ext << K_LO)) begin
					rem_nx       = rem_mid - (den_ext << K_LO);
					quo_nx[K_LO] = 1'b1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[j] <= 1'b0;
				end else if (rdy[j]) begin
					v_s[j] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[j]) begin
					rem_s[j]   <= rem_nx;
					quo_s[j]   <= quo_nx;
					sat_s[j]   <= sat_in;
					alpha_s[j] <= alpha_pre;
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = v_s[LAST];
	assign quo       = sat_s[LAST] ? '1 : quo_s[LAST];
	assign alpha_out = alpha_s[LAST];

`ifndef NO_ASSERTIONS
	a_rem_first: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] && !sat_s[0] |-> rem_s[0] < (den_ext << (Q_W - DIV_BITS)))
		else $error("divider remainder out of range after first stage");
	a_rem_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[LAST] && !sat_s[LAST] |-> rem_s[LAST] < den_ext)
		else $error("divider remainder not below divisor");
	a_flow: assert property (@(posedge clk) out_ready |-> in_ready)
		else $error("divider stalls input while output is free");
`endif

endmodule

// File: rtl/core/pixel_weighted_intensity_contrast_top.sv
`timescale 1ns / 1ps

// Converts RGBA pixels to a gray level with a weighted combine, a brightness
// scale with saturation and a contrast curve around mid-gray, and passes alpha.
// The pixel channel takes one item per clock while the pipeline has room, and
// the result channel gives one gray level and alpha for every accepted item, in
// order. The cfg channel writes at most one register per accepted write and is always
// ready; registers must only be written while no item is in flight.
// Throughput is one item per cycle while the result side accepts; the design is a
// ten-stage pipeline in which the division by full scale times the effective weight
// sum is done two quotient bits per stage over four stages.
// Reset empties the pipeline and loads the register defaults: average mode,
// red, green and blue weights of 1.0, alpha weight 0, scale 1.0, contrast 1.0.
// When the receiver stalls, the output register holds its item, earlier stages
// keep filling any empty slots, and pixel ready falls only once every stage is
// occupied. Nothing is lost or repeated across a stall.

module pixel_weighted_intensity_contrast_top import pwic_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	pwic_pixel_if.sink   pixel,
	pwic_gray_if.source  result,
	pwic_cfg_if.sink     cfg
);

	localparam int DEN_W = WSUM_W + CH_W;
	localparam logic [DEN_W-1:0] DEN_RST =
		DEN_W'((WSUM_RST << CH_W) - WSUM_RST);

	logic                     mode_q;
	logic [WT_W-1:0]          red_wt_q;
	logic [WT_W-1:0]          green_wt_q;
	logic [WT_W-1:0]          blue_wt_q;
	logic [WT_W-1:0]          alpha_wt_q;
	logic [WT_W-1:0]          scale_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic [DEN_W-1:0]         den_q;

	logic [WSUM_W-1:0] wsum;
	logic [WSUM_W-1:0] w_sel;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s9, v_s10;
	logic                   rdy1, rdy2, rdy3, rdy4, rdy9, rdy10;
	logic [PROD_W-1:0]      pr_s1, pg_s1, pb_s1, pa_s1;
	logic [CH_W-1:0]        alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s9, alpha_s10;
	logic [SUM_W-1:0]       x_s2;
	logic [SCALED_W-1:0]    p_s3;
	logic [NUM_W-1:0]       n_s4;
	logic signed [T_W-1:0]  t_s9;
	logic [Q_W-1:0]         gray_s10;

	logic [SUM_W-1:0]       sum;
	logic [PROD_W-1:0]      max_a;
	logic [PROD_W-1:0]      max_b;
	logic [PROD_W-1:0]      max_p;
	logic [SCALED_W+7:0]    times255;

	logic                   div_in_ready;
	logic                   div_valid;
	logic [Q_W-1:0]         div_quo;
	logic [CH_W-1:0]        div_alpha;
	logic signed [DIFF_W-1:0]       diff;
	logic signed [DIFF_W+GAIN_W-1:0] cprod;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RST;
			red_wt_q   <= RED_WT_RST;
			green_wt_q <= GREEN_WT_RST;
			blue_wt_q  <= BLUE_WT_RST;
			alpha_wt_q <= ALPHA_WT_RST;
			scale_q    <= SCALE_RST;
			gain_q     <= GAIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_COMBINE_MODE: mode_q     <= cfg.data[0];
				REG_RED_WEIGHT:   red_wt_q   <= cfg.data;
				REG_GREEN_WEIGHT: green_wt_q <= cfg.data;
				REG_BLUE_WEIGHT:  blue_wt_q  <= cfg.data;
				REG_ALPHA_WEIGHT: alpha_wt_q <= cfg.data;
				REG_SCALE:        scale_q    <= cfg.data;
				REG_CONTRAST:     gain_q     <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	// The divisor is the channel full scale times the effective weight sum.
	assign wsum = WSUM_W'(red_wt_q) + WSUM_W'(green_wt_q) + WSUM_W'(blue_wt_q)
		+ WSUM_W'(alpha_wt_q);
	assign w_sel = (mode_q || wsum == '0) ? W_ONE : wsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= DEN_RST;
		end else begin
			den_q <= (DEN_W'(w_sel) << CH_W) - DEN_W'(w_sel);
		end
	end

	assign rdy10 = !v_s10 || result.ready;
	assign rdy9  = !v_s9 || rdy10;
	assign rdy4  = !v_s4 || div_in_ready;
	assign rdy3  = !v_s3 || rdy4;
	assign rdy2  = !v_s2 || rdy3;
	assign rdy1  = !v_s1 || rdy2;
	assign pixel.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= pixel.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy9) begin
				v_s9 <= div_valid;
			end
			if (rdy10) begin
				v_s10 <= v_s9;
			end
		end
	end

	always_comb begin
		sum   = SUM_W'(pr_s1) + SUM_W'(pg_s1) + SUM_W'(pb_s1) + SUM_W'(pa_s1);
		max_a = (pg_s1 > pr_s1) ? pg_s1 : pr_s1;
		max_b = (pa_s1 > pb_s1) ? pa_s1 : pb_s1;
		max_p = (max_b > max_a) ? max_b : max_a;
	end

	assign times255 = {p_s3, 8'd0} - {8'd0, p_s3};

	always_ff @(posedge clk) begin
		if (rdy1) begin
			pr_s1    <= PROD_W'(pixel.red_in) * PROD_W'(red_wt_q);
			pg_s1    <= PROD_W'(pixel.green_in) * PROD_W'(green_wt_q);
			pb_s1    <= PROD_W'(pixel.blue_in) * PROD_W'(blue_wt_q);
			pa_s1    <= PROD_W'(pixel.alpha_in) * PROD_W'(alpha_wt_q);
			alpha_s1 <= pixel.alpha_in;
		end
		if (rdy2) begin
			x_s2     <= mode_q ? SUM_W'(max_p) : sum;
			alpha_s2 <= alpha_s1;
		end
		if (rdy3) begin
			p_s3     <= SCALED_W'(x_s2) * SCALED_W'(scale_q);
			alpha_s3 <= alpha_s2;
		end
		if (rdy4) begin
			n_s4     <= times255[SCALED_W+7:FRAC_SHIFT];
			alpha_s4 <= alpha_s3;
		end
	end

	pwic_div #(
		.DEN_W (DEN_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.num       (n_s4),
		.den       (den_q),
		.alpha_in  (alpha_s4),
		.out_valid (div_valid),
		.out_ready (rdy9),
		.quo       (div_quo),
		.alpha_out (div_alpha)
	);

	assign diff  = $signed({1'b0, div_quo, 1'b0}) - DIFF_W'(255);
	assign cprod = diff * gain_q;

	always_ff @(posedge clk) begin
		if (rdy9) begin
			t_s9     <= T_W'(cprod) + T_W'(CONTRAST_BIAS);
			alpha_s9 <= div_alpha;
		end
		if (rdy10) begin
			if (t_s9[T_W-1]) begin
				gray_s10 <= '0;
			end else if (|t_s9[T_W-2:CONTRAST_SHIFT+Q_W]) begin
				gray_s10 <= '1;
			end else begin
				gray_s10 <= t_s9[CONTRAST_SHIFT+Q_W-1:CONTRAST_SHIFT];
			end
			alpha_s10 <= alpha_s9;
		end
	end

	assign result.valid      = v_s10;
	assign result.gray_level = gray_s10;
	assign result.alpha_out  = alpha_s10;

`ifndef NO_ASSERTIONS
	a_no_block: assert property (@(posedge clk) result.ready |-> pixel.ready)
		else $error("pixel input stalled while result side is free");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n) den_q != '0)
		else $error("divisor is zero");
	a_clamp_low: assert property (@(posedge clk) disable iff (!arst_n)
		rdy10 && v_s9 && t_s9[T_W-1] |=> result.gray_level == '0)
		else $error("negative contrast value not clamped to zero");
`endif

endmodule

// File: tb/tb_pixel_weighted_intensity_contrast_top.sv
`timescale 1ns / 1ps

module tb_pixel_weighted_intensity_contrast_top;
	import pwic_pkg::*;

	localparam int LATENCY_CYCLES = 10;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 83;
	localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [REG_IDX_W-1:0] index;
		logic [WT_W-1:0]      data;
		logic [CH_W-1:0]      red;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      blue;
		logic [CH_W-1:0]      alpha;
		logic                 known;
		logic [Q_W-1:0]       gray;
	} plan_row_t;

	typedef struct packed {
		logic [Q_W-1:0]  gray;
		logic [CH_W-1:0] alpha;
	} gray_pixel_t;

	localparam int PLAN_ROWS = 38;
	localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'h55, 8'hAA, 8'h0F, 8'hF0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_CONTRAST, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd200, 8'd10, 8'd30, 8'd77, 1'b1, 8'd127},
		'{ROW_WRITE, REG_CONTRAST, 16'h8000, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd9, 1'b1, 8'd255},
		'{ROW_WRITE, REG_CONTRAST, 16'h7FFF, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0},
		'{ROW_WRITE, REG_CONTRAST, 16'd4096, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_SCALE, 16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd128, 8'd128, 8'd128, 8'd1, 1'b1, 8'd255},
		'{ROW_WRITE, REG_SCALE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
		'{ROW_WRITE, REG_SCALE, 16'd4096, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_RED_WEIGHT, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_GREEN_WEIGHT, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_BLUE_WEIGHT, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_ALPHA_WEIGHT, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
		'{ROW_WRITE, REG_NONE, 16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd170, 8'd85, 8'd1, 8'd254, 1'b1, 8'd0},
		'{ROW_WRITE, REG_COMBINE_MODE, 16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_RED_WEIGHT, 16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 8'd255},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0},
		'{ROW_WRITE, REG_ALPHA_WEIGHT, 16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 8'd255},
		'{ROW_WRITE, REG_GREEN_WEIGHT, 16'd2048, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_BLUE_WEIGHT, 16'd1234, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd90, 8'd200, 8'd17, 8'd3, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd17, 8'd255, 8'd2, 8'd0, 1'b0, 8'd0},
		'{ROW_WRITE, REG_COMBINE_MODE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'hFF, 8'h80, 8'h7F, 8'h01, 1'b0, 8'd0},
		'{ROW_PIXEL, REG_NONE, 16'd0, 8'd1, 8'd2, 8'd4, 8'd8, 1'b0, 8'd0}
	};

	logic clk;
	logic arst_n;

	pwic_pixel_if pixel();
	pwic_gray_if  result();
	pwic_cfg_if   cfg();

	pixel_weighted_intensity_contrast_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.result(result),
		.cfg(cfg)
	);

	logic                     max_mode;
	logic [WT_W-1:0]          w_red;
	logic [WT_W-1:0]          w_green;
	logic [WT_W-1:0]          w_blue;
	logic [WT_W-1:0]          w_alpha;
	logic [WT_W-1:0]          brightness;
	logic signed [GAIN_W-1:0] gain;

	gray_pixel_t gray_due_q[$];
	bit          no_gaps;
	int          failures;
	int          pixels_sent;
	int          directed_pixels;
	int          results_seen;
	int          reg_writes;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic logic [Q_W-1:0] weighted_gray(input logic [CH_W-1:0] r, g, b, a);
		longint unsigned pr, pg, pb, pa, wsum, peak, num, den, level, q;
		longint          t;
		pr = 64'(r) * 64'(w_red);
		pg = 64'(g) * 64'(w_green);
		pb = 64'(b) * 64'(w_blue);
		pa = 64'(a) * 64'(w_alpha);
		if (!max_mode) begin
			wsum = 64'(w_red) + 64'(w_green) + 64'(w_blue) + 64'(w_alpha);
			if (wsum == 0)
				wsum = 4096;
			num = (pr + pg + pb + pa) * 64'(brightness) * 255;
			den = 255 * wsum * 4096;
		end else begin
			peak = pr;
			if (pg > peak)
				peak = pg;
			if (pb > peak)
				peak = pb;
			if (pa > peak)
				peak = pa;
			num = peak * 64'(brightness) * 255;
			den = 64'd255 * 4096 * 4096;
		end
		level = num / den;
		if (level > 255)
			level = 255;
		// Curve in units of 1/8192: (2c - 255) * gain + 255 * 4096.
		t = (longint'(2 * level) - 64'sd255) * longint'(gain) + 64'sd1044480;
		if (t < 0)
			return '0;
		q = longint'(t) / 8192;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic logic [WT_W-1:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return Q_ONE;
			3: return 16'($urandom_range(0, 8191));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [CH_W-1:0] pick_channel();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WT_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (cfg.ready !== 1'b1)
			@(posedge clk);
		reg_writes++;
		case (idx)
			REG_COMBINE_MODE: max_mode = value[0];
			REG_RED_WEIGHT:   w_red = value;
			REG_GREEN_WEIGHT: w_green = value;
			REG_BLUE_WEIGHT:  w_blue = value;
			REG_ALPHA_WEIGHT: w_alpha = value;
			REG_SCALE:        brightness = value;
			REG_CONTRAST:     gain = value;
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [CH_W-1:0] r, g, b, a, input logic known,
			input logic [Q_W-1:0] known_gray);
		int          gap;
		gray_pixel_t due;
		gap = draw_gap();
		if (gap > 0) begin
			pixel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.red_in <= r;
		pixel.green_in <= g;
		pixel.blue_in <= b;
		pixel.alpha_in <= a;
		@(posedge clk);
		while (pixel.ready !== 1'b1)
			@(posedge clk);
		due.gray = known ? known_gray : weighted_gray(r, g, b, a);
		due.alpha = a;
		gray_due_q.push_back(due);
		pixels_sent++;
	endtask

	task automatic wait_drained();
		pixel.valid <= 1'b0;
		while (gray_due_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY_CYCLES + 2) @(posedge clk);
	endtask

	task automatic check_result(input logic [Q_W-1:0] gray, input logic [CH_W-1:0] alpha);
		gray_pixel_t due;
		if (gray_due_q.size() == 0) begin
			$error("unexpected item: gray_level %0d alpha_out %0d", gray, alpha);
			failures++;
			return;
		end
		due = gray_due_q.pop_front();
		results_seen++;
		if (gray !== due.gray) begin
			$error("gray_level: expected %0d, actual %0d", due.gray, gray);
			failures++;
		end
		if (alpha !== due.alpha) begin
			$error("alpha_out: expected %0d, actual %0d", due.alpha, alpha);
			failures++;
		end
	endtask

	initial begin
		int gap;
		result.ready = 1'b0;
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (result.valid !== 1'b1)
				@(posedge clk);
			check_result(result.gray_level, result.alpha_out);
		end
	end

	initial begin
		bit              writing;
		logic [WT_W-1:0] gain_pick;
		arst_n = 1'b0;
		pixel.valid = 1'b0;
		pixel.red_in = '0;
		pixel.green_in = '0;
		pixel.blue_in = '0;
		pixel.alpha_in = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		max_mode = MODE_RST;
		w_red = RED_WT_RST;
		w_green = GREEN_WT_RST;
		w_blue = BLUE_WT_RST;
		w_alpha = ALPHA_WT_RST;
		brightness = SCALE_RST;
		gain = GAIN_RST;
		no_gaps = 1'b0;
		writing = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				if (!writing)
					wait_drained();
				writing = 1'b1;
				write_reg(PLAN[i].index, PLAN[i].data);
			end else begin
				if (writing)
					cfg.valid <= 1'b0;
				writing = 1'b0;
				send_pixel(PLAN[i].red, PLAN[i].green, PLAN[i].blue, PLAN[i].alpha,
					PLAN[i].known, PLAN[i].gray);
			end
		end
		directed_pixels = pixels_sent;

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			no_gaps = ($urandom_range(0, 3) == 0);
			write_reg(REG_COMBINE_MODE, {15'($urandom_range(0, 32767)), p[0]});
			write_reg(REG_RED_WEIGHT, pick_weight());
			write_reg(REG_GREEN_WEIGHT, pick_weight());
			write_reg(REG_BLUE_WEIGHT, pick_weight());
			write_reg(REG_ALPHA_WEIGHT, pick_weight());
			write_reg(REG_SCALE, pick_weight());
			case ($urandom_range(0, 4))
				0: gain_pick = 16'h8000;
				1: gain_pick = 16'h7FFF;
				2: gain_pick = GAIN_RST;
				3: gain_pick = 16'($urandom_range(0, 8192));
				default: gain_pick = 16'($urandom_range(0, 65535));
			endcase
			write_reg(REG_CONTRAST, gain_pick);
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
			cfg.valid <= 1'b0;
			repeat (ITEMS_PER_PHASE)
				send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
					1'b0, '0);
		end

		wait_drained();
		$display("Sent %0d pixels (%0d directed) and checked %0d results.",
			pixels_sent, directed_pixels, results_seen);
		$display("Made %0d register writes over %0d random settings in both combine modes.",
			reg_writes, PHASES);
		if (failures == 0)
			$display("tb_pixel_weighted_intensity_contrast_top: PASS");
		else
			$display("tb_pixel_weighted_intensity_contrast_top: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_pixel_weighted_intensity_contrast_top: FAIL");
		$finish;
	end

endmodule
